### sv/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/infx_pkg.sv
// Types, token codes and the precedence function of the infix-to-prefix converter.
package infx_pkg;

    // input token kinds
    localparam logic [2:0] MODE_OPERAND = 3'd0;
    localparam logic [2:0] MODE_OPERATOR = 3'd1;
    localparam logic [2:0] MODE_LBRK = 3'd2;
    localparam logic [2:0] MODE_RBRK = 3'd3;
    localparam logic [2:0] MODE_END = 3'd4;

    // emitted token kinds
    localparam logic [1:0] KIND_OPERAND = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam int ENTRY_W = 3;
    localparam logic [ENTRY_W-1:0] RB_MARK = 3'd4;   // stacked right bracket
    localparam int ID_W = 16;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ENTRY_W-1:0] wr_data;
    } t_stk_ctl;

    // precedence: mul/div 2, add/sub 1, bracket mark 0
    function automatic logic [1:0] rank_of(input logic [ENTRY_W-1:0] entry);
        logic [1:0] r;
        case (entry)
            {1'b0, OP_MUL}, {1'b0, OP_DIV}: r = 2'd2;
            {1'b0, OP_ADD}, {1'b0, OP_SUB}: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/infx_stack.sv
// Operator stack memory: one write port, one registered read port.
module infx_stack
    import infx_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                           i_clk,
    input  t_stk_ctl                       i_ctl,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_rd_addr,
    output logic [ENTRY_W-1:0]             o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/infix_to_prefix_converter_core.sv
// Top level of the infix-to-prefix converter: token sequencer and output register.
//
// Converts an infix token stream, fed last token first, into prefix order
// (read the output stream backwards) with a shunting-yard operator stack.
// An operand beat gives one result at once; a right bracket gives none.
// An operator, left bracket or end token runs read passes over the stack,
// one per stack entry examined, plus one more when the scan finds the
// stack empty. Each pass reads the top entry through the single registered
// read port of the stack memory in ST_RD and ranks it in ST_CHK, at most
// one popped operator leaving per pass. An end token always scans until
// the stack is empty and then sends its end marker from ST_END. Popped
// operators are held back one step so that the final result of each input
// beat carries tlast. The stack holds STACK_DEPTH entries; a push onto a
// full stack is dropped and sets a sticky overflow flag that rides on
// every result. Output stalls (i_m_tready low) stretch every ST_CHK and
// ST_END step, whether or not it has a result to hand over. s_tready is
// high only in idle with the output register free. Unused modes 5..7 are
// accepted and ignored. The stack memory needs no clearing: only entries
// below the count are read.
`include "assert_macros.svh"

module infix_to_prefix_converter_core
    import infx_pkg::*;
#(
    parameter int STACK_DEPTH  = 16,
    parameter int OPERAND_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input token beat
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [1:0] operator_code, [17:2] operand_id
    input  logic [2:0]  i_s_tuser,   // [2:0] mode
    // output token beat
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [1:0] token_operator, [17:2] token_operand,
                                     // [18] stack_overflow
    output logic [1:0]  o_m_tuser,   // [1:0] token_kind
    output logic        o_m_tlast    // last_of_run
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int OPW = (OPERAND_BITS < ID_W) ? OPERAND_BITS : ID_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,     // issue read of the top entry
        ST_CHK,    // rank the top entry, pop or finish
        ST_END     // send the end marker
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_overflow, n_overflow;
    logic [2:0]         r_mode, n_mode;
    logic [1:0]         r_opc, n_opc;
    logic               r_pend_vld, n_pend_vld;
    logic [1:0]         r_pend_op, n_pend_op;

    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_kind, n_out_kind;
    logic [1:0]         r_out_op, n_out_op;
    logic [OPW-1:0]     r_out_operand, n_out_operand;
    logic               r_out_last, n_out_last;
    logic               r_out_ovf, n_out_ovf;

    t_stk_ctl           stk_ctl;
    logic [ENTRY_W-1:0] stk_top;
    logic [CW-1:0]      cnt_dec;
    logic               out_free;
    logic               s_acc;
    logic               full;
    logic               empty;
    logic               do_push;
    logic [ENTRY_W-1:0] push_data;
    logic               emit;
    logic [1:0]         emit_kind;
    logic [1:0]         emit_op;
    logic               emit_last;

    assign cnt_dec    = r_cnt - 1'b1;
    assign full       = (r_cnt == CW'(STACK_DEPTH));
    assign empty      = (r_cnt == '0);
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;

    infx_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_ctl    (stk_ctl),
        .i_wr_addr(r_cnt[AW-1:0]),
        .i_rd_addr(cnt_dec[AW-1:0]),
        .o_rd_data(stk_top)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_overflow = r_overflow;
        n_mode     = r_mode;
        n_opc      = r_opc;
        n_pend_vld = r_pend_vld;
        n_pend_op  = r_pend_op;
        do_push    = 1'b0;
        push_data  = RB_MARK;
        emit       = 1'b0;
        emit_kind  = KIND_OPERATOR;
        emit_op    = r_pend_op;
        emit_last  = 1'b0;
        stk_ctl    = '0;

        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_kind    = r_out_kind;
        n_out_op      = r_out_op;
        n_out_operand = r_out_operand;
        n_out_last    = r_out_last;
        n_out_ovf     = r_out_ovf;

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    case (i_s_tuser)
                        MODE_OPERAND: begin
                            // operand goes straight to the output register
                            n_out_valid   = 1'b1;
                            n_out_kind    = KIND_OPERAND;
                            n_out_op      = 2'd0;
                            n_out_operand = i_s_tdata[2 +: OPW];
                            n_out_last    = 1'b1;
                            n_out_ovf     = r_overflow;
                        end
                        MODE_OPERATOR, MODE_LBRK, MODE_END: begin
                            n_mode     = i_s_tuser;
                            n_opc      = i_s_tdata[1:0];
                            n_pend_vld = 1'b0;
                            n_state    = ST_RD;
                        end
                        MODE_RBRK: begin
                            do_push   = 1'b1;
                            push_data = RB_MARK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD: begin
                stk_ctl.rd_en = !empty;
                n_state       = ST_CHK;
            end
            ST_CHK: begin
                if (out_free) begin
                    case (r_mode)
                        MODE_OPERATOR: begin
                            if (!empty && (rank_of(stk_top) > rank_of({1'b0, r_opc}))) begin
                                n_cnt      = cnt_dec;
                                emit       = r_pend_vld;
                                n_pend_vld = 1'b1;
                                n_pend_op  = stk_top[1:0];
                                n_state    = ST_RD;
                            end else begin
                                emit      = r_pend_vld;
                                emit_last = 1'b1;
                                do_push   = 1'b1;
                                push_data = {1'b0, r_opc};
                                n_state   = ST_IDLE;
                            end
                        end
                        MODE_LBRK: begin
                            if (!empty && (stk_top != RB_MARK)) begin
                                n_cnt      = cnt_dec;
                                emit       = r_pend_vld;
                                n_pend_vld = 1'b1;
                                n_pend_op  = stk_top[1:0];
                                n_state    = ST_RD;
                            end else begin
                                // matching bracket dropped, or stack ran dry
                                if (!empty) begin
                                    n_cnt = cnt_dec;
                                end
                                emit      = r_pend_vld;
                                emit_last = 1'b1;
                                n_state   = ST_IDLE;
                            end
                        end
                        default: begin
                            // end token: flush, brackets vanish
                            if (!empty) begin
                                n_cnt   = cnt_dec;
                                n_state = ST_RD;
                                if (stk_top != RB_MARK) begin
                                    emit       = r_pend_vld;
                                    n_pend_vld = 1'b1;
                                    n_pend_op  = stk_top[1:0];
                                end
                            end else begin
                                emit    = r_pend_vld;
                                n_state = ST_END;
                            end
                        end
                    endcase
                end
            end
            ST_END: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                    emit_op   = 2'd0;
                    emit_last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // push, dropped on a full stack
        if (do_push) begin
            if (full) begin
                n_overflow = 1'b1;
            end else begin
                stk_ctl.wr_en   = 1'b1;
                stk_ctl.wr_data = push_data;
                n_cnt           = r_cnt + 1'b1;
            end
        end

        // a pending pop implies no overflow this item, so the current flag is final
        if (emit) begin
            n_out_valid   = 1'b1;
            n_out_kind    = emit_kind;
            n_out_op      = emit_op;
            n_out_operand = '0;
            n_out_last    = emit_last;
            n_out_ovf     = r_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_overflow  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_overflow  <= n_overflow;
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= n_out_valid;
        end
        r_mode        <= n_mode;
        r_opc         <= n_opc;
        r_pend_op     <= n_pend_op;
        r_out_kind    <= n_out_kind;
        r_out_op      <= n_out_op;
        r_out_operand <= n_out_operand;
        r_out_last    <= n_out_last;
        r_out_ovf     <= n_out_ovf;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {5'd0, r_out_ovf, ID_W'(r_out_operand), r_out_op};

    `ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH),
                "stack count past depth")
    `ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_overflow, r_overflow,
                 "overflow flag cleared")
    `ASSERT_NEXT(a_operand_out, i_clk, i_rst_n, s_acc && (i_s_tuser == MODE_OPERAND),
                 o_m_tvalid && o_m_tlast && (o_m_tuser == KIND_OPERAND),
                 "operand beat not sent next cycle")
    `ASSERT_IMP(a_end_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_END),
                o_m_tlast, "end marker without tlast")

endmodule
